// File: hdl/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types and constants for the LIFO stack allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsa_pkg;

  localparam int unsigned POOL_BYTES_DEF = 1024;
  localparam int unsigned MAX_BLOCKS_DEF = 64;

  localparam int unsigned OFF_W   = 11;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned ELEM_W  = 4;
  localparam int unsigned BYTES_W = COUNT_W + ELEM_W;
  localparam int unsigned STAT_W  = 3;

  localparam logic [ELEM_W-1:0] ELEM_BYTES_RST = 4'd4;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_ORDER     = 3'd2,
    ST_FULL      = 3'd3,
    ST_OVERFREE  = 3'd4
  } status_e;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

// File: hdl/lsa_cell.sv
// ----------------------------------------------------------------------------
// lsa_cell
// One slot of the record stack. On a push it takes the word from the slot
// above, on a pop the word from the slot below, and otherwise it holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsa_cell #(
  parameter int unsigned DW = lsa_pkg::OFF_W
) (
  input  logic           clk_i,
  input  lsa_pkg::shift_t ctrl_i,
  input  logic [DW-1:0]  above_i,
  input  logic [DW-1:0]  below_i,
  output logic [DW-1:0]  data_o
);

  logic [DW-1:0] data_q;
  logic [DW-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.push) begin
      data_d = above_i;
    end else if (ctrl_i.pop) begin
      data_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: hdl/lsa_stack.sv
// ----------------------------------------------------------------------------
// lsa_stack
// Row of record cells; cell 0 holds the most recent block start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsa_stack #(
  parameter int unsigned DEPTH = lsa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned DW    = lsa_pkg::OFF_W
) (
  input  logic            clk_i,
  input  lsa_pkg::shift_t ctrl_i,
  input  logic [DW-1:0]   push_data_i,
  output logic [DW-1:0]   top_o
);

  logic [DW-1:0] cell_data [DEPTH];
  logic [DW-1:0] cell_above [DEPTH];
  logic [DW-1:0] cell_below [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign cell_above[g] = push_data_i;
    end else begin : g_mid
      assign cell_above[g] = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign cell_below[g] = '0;
    end else begin : g_inner
      assign cell_below[g] = cell_data[g+1];
    end

    lsa_cell #(
      .DW(DW)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .above_i(cell_above[g]),
      .below_i(cell_below[g]),
      .data_o (cell_data[g])
    );
  end

  assign top_o = cell_data[0];

endmodule

// File: hdl/lifo_stack_allocator.sv
// A bump allocator over a byte pool of POOL_BYTES bytes with a record of up to
// MAX_BLOCKS block starts. Each word carries an allocate or a free command and
// is answered by one result word with an offset and a status. A command is
// decided in the cycle it is accepted and its result is registered, so one
// command is taken per cycle while no held result stalls input; the record of
// block starts is a row of shift cells moved whole in that same cycle.
// ----------------------------------------------------------------------------
// lifo_stack_allocator
// Top level: command decode, free offset and block count, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lifo_stack_allocator #(
  parameter int unsigned POOL_BYTES = lsa_pkg::POOL_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS = lsa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lsa_pkg::ELEM_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [lsa_pkg::COUNT_W-1:0]  count_i,
  input  logic [lsa_pkg::OFF_W-1:0]    block_offset_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lsa_pkg::OFF_W-1:0]    offset_o,
  output logic [lsa_pkg::STAT_W-1:0]   status_o
);

  localparam int unsigned FW  = $clog2(POOL_BYTES + 1);
  localparam int unsigned CNW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CW  = (FW > lsa_pkg::OFF_W) ? FW : lsa_pkg::OFF_W;
  localparam int unsigned SW  = ((FW > lsa_pkg::BYTES_W) ? FW : lsa_pkg::BYTES_W) + 1;

  logic [lsa_pkg::ELEM_W-1:0]  elem_q;
  logic [FW-1:0]               free_q, free_d;
  logic [CNW-1:0]              cnt_q, cnt_d;
  logic                        ovalid_q, ovalid_d;
  logic [lsa_pkg::OFF_W-1:0]   offset_q, offset_d;
  lsa_pkg::status_e            status_q, status_d;

  logic                        accept;
  logic [lsa_pkg::BYTES_W-1:0] bytes;
  logic [SW-1:0]               sum;
  logic [FW-1:0]               top;
  lsa_pkg::shift_t             shift;

  assign in_ready_o = !ovalid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign bytes      = lsa_pkg::BYTES_W'(count_i) * lsa_pkg::BYTES_W'(elem_q);
  assign sum        = SW'(free_q) + SW'(bytes);

  always_comb begin
    free_d   = free_q;
    cnt_d    = cnt_q;
    shift    = '0;
    offset_d = offset_q;
    status_d = status_q;
    ovalid_d = ovalid_q && !out_ready_i;
    if (accept) begin
      ovalid_d = 1'b1;
      offset_d = '0;
      status_d = lsa_pkg::ST_OK;
      if (lsa_pkg::cmd_e'(command_i) == lsa_pkg::CMD_ALLOC) begin
        if (sum > SW'(POOL_BYTES)) begin
          status_d = lsa_pkg::ST_EXHAUSTED;
        end else if (cnt_q == CNW'(MAX_BLOCKS)) begin
          status_d = lsa_pkg::ST_FULL;
        end else begin
          offset_d   = lsa_pkg::OFF_W'(CW'(free_q));
          shift.push = 1'b1;
          cnt_d      = cnt_q + CNW'(1);
          free_d     = FW'(sum);
        end
      end else begin
        if (cnt_q == '0 || CW'(top) != CW'(block_offset_i)) begin
          status_d = lsa_pkg::ST_ORDER;
        end else if (SW'(bytes) > SW'(free_q)) begin
          status_d = lsa_pkg::ST_OVERFREE;
        end else begin
          shift.pop = 1'b1;
          cnt_d     = cnt_q - CNW'(1);
          free_d    = FW'(SW'(free_q) - SW'(bytes));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q   <= lsa_pkg::ELEM_BYTES_RST;
      free_q   <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        elem_q <= cfg_wdata_i;
      end
      free_q   <= free_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    offset_q <= offset_d;
    status_q <= status_d;
  end

  lsa_stack #(
    .DEPTH(MAX_BLOCKS),
    .DW   (FW)
  ) u_stack (
    .clk_i      (clk_i),
    .ctrl_i     (shift),
    .push_data_i(free_q),
    .top_o      (top)
  );

  assign out_valid_o = ovalid_q;
  assign offset_o    = offset_q;
  assign status_o    = status_q;

endmodule
